@@ hw/rtl/spp_pkg.sv @@
// ----------------------------------------------------------------------------
// spp_pkg
// Shared widths, constants and controller/datapath interface types for the
// stride prefetch predictor.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int PAGE_ID_BITS  = 52;
    localparam int TIME_BITS     = 48;
    localparam int STRIDE_BITS   = 32;
    localparam int TAU_BITS      = 32;
    localparam int CONF_BITS     = 4;
    localparam int DEPTH_BITS    = 4;
    localparam int BUDGET_BITS   = 16;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_DEPTH_BUDGET   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONF_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONF_LIMIT     = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEPTH_LIMIT    = 2'd3;

    localparam int TAU_OLD_WEIGHT = 85;
    localparam int TAU_NEW_WEIGHT = 15;
    localparam int TAU_DIVISOR    = 100;

    localparam int DIV_DIGIT_BITS  = 8;
    localparam int NUM_BITS        = TAU_BITS + DIV_DIGIT_BITS;
    localparam int REM_BITS        = 7;
    localparam int DIV_STEPS       = NUM_BITS / DIV_DIGIT_BITS;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);
    localparam int DIV_RECIP       = 5243;
    localparam int DIV_RECIP_BITS  = 13;
    localparam int DIV_RECIP_SHIFT = 19;

    localparam int DEPTH_STEPS     = DEPTH_BITS;
    localparam int DEPTH_CNT_BITS  = $clog2(DEPTH_STEPS);
    localparam int DEPTH_CMP_BITS  = TAU_BITS + 1 + DEPTH_STEPS - 1;

    localparam int S_TDATA_BITS = ((PAGE_ID_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = PAGE_ID_BITS + STRIDE_BITS + DEPTH_BITS + TAU_BITS
                                  + CONF_BITS + TAU_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                      load;
        logic                      calc;
        logic                      div_step;
        logic                      div_last;
        logic                      depth_step;
        logic [DEPTH_CNT_BITS-1:0] depth_shift;
        logic                      finish;
    } spp_cmd_t;

    typedef struct packed {
        logic is_start;
        logic tau_update;
    } spp_status_t;

endpackage

@@ hw/rtl/spp_ctrl.sv @@
// ----------------------------------------------------------------------------
// spp_ctrl
// Sequencer for the predictor: accepts a transfer, steps a read through update,
// division by one hundred when the average is updated, and depth steps, then
// hands the result to the output register; a start event goes straight there.
// ----------------------------------------------------------------------------
module spp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  spp_pkg::spp_status_t status,
    output spp_pkg::spp_cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DEPTH,
        ST_FINISH
    } state_t;

    state_t                                state_reg;
    logic [spp_pkg::DIV_CNT_BITS-1:0]      div_cnt_reg;
    logic [spp_pkg::DEPTH_CNT_BITS-1:0]    depth_cnt_reg;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic                                  out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_valid_next = ((state_reg == ST_FINISH) && out_free) ? 1'b1
                          : (out_valid_reg && !m_tready);

    always_comb
    begin
        cmd             = '0;
        cmd.depth_shift = depth_cnt_reg;
        unique case (state_reg)
            ST_IDLE:   cmd.load = s_tvalid;
            ST_CALC:   cmd.calc = !status.is_start;
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (div_cnt_reg == '0);
            end
            ST_DEPTH:  cmd.depth_step = 1'b1;
            ST_FINISH: cmd.finish = out_free;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            depth_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        depth_cnt_reg <= spp_pkg::DEPTH_CNT_BITS'(spp_pkg::DEPTH_STEPS - 1);
                        state_reg     <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (status.is_start)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (status.tau_update)
                    begin
                        div_cnt_reg <= spp_pkg::DIV_CNT_BITS'(spp_pkg::DIV_STEPS - 1);
                        state_reg   <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_DEPTH;
                    end
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= ST_DEPTH;
                    end
                end
                ST_DEPTH:
                begin
                    depth_cnt_reg <= depth_cnt_reg - 1'b1;
                    if (depth_cnt_reg == '0)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/spp_datapath.sv @@
// ----------------------------------------------------------------------------
// spp_datapath
// Configuration registers, predictor state, moving-average product, a
// reciprocal divider by one hundred that takes one byte per cycle, the depth
// divider and the output register.
// ----------------------------------------------------------------------------
module spp_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [spp_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [spp_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                  in_kind,
    input  logic [spp_pkg::PAGE_ID_BITS-1:0]      in_page_id,
    input  logic [spp_pkg::TIME_BITS-1:0]         in_time_us,
    input  spp_pkg::spp_cmd_t                     cmd,
    output spp_pkg::spp_status_t                  status,
    output logic                                  issue,
    output logic [spp_pkg::PAGE_ID_BITS-1:0]      base_page,
    output logic signed [spp_pkg::STRIDE_BITS-1:0] stride,
    output logic [spp_pkg::DEPTH_BITS-1:0]        depth,
    output logic [spp_pkg::TAU_BITS-1:0]          tau_us,
    output logic [spp_pkg::CONF_BITS-1:0]         confidence,
    output logic [spp_pkg::TAU_BITS-1:0]          fired_count
);

    localparam int PB  = spp_pkg::PAGE_ID_BITS;
    localparam int TB  = spp_pkg::TIME_BITS;
    localparam int SB  = spp_pkg::STRIDE_BITS;
    localparam int AB  = spp_pkg::TAU_BITS;
    localparam int CB  = spp_pkg::CONF_BITS;
    localparam int DB  = spp_pkg::DEPTH_BITS;
    localparam int BB  = spp_pkg::BUDGET_BITS;
    localparam int NB  = spp_pkg::NUM_BITS;
    localparam int RB  = spp_pkg::REM_BITS;
    localparam int GB  = spp_pkg::DIV_DIGIT_BITS;
    localparam int EB  = RB + GB;
    localparam int MB  = EB + spp_pkg::DIV_RECIP_BITS;
    localparam int XB  = spp_pkg::DEPTH_CMP_BITS;
    localparam int WIDE_BITS = 65;

    // Configuration.
    logic [BB-1:0] budget_reg;
    logic [CB-1:0] conf_threshold_reg;
    logic [CB-1:0] conf_limit_reg;
    logic [DB-1:0] depth_limit_reg;

    // Latched transfer.
    logic          kind_reg;
    logic [PB-1:0] page_reg;
    logic [TB-1:0] time_reg;

    // Predictor state.
    logic [AB-1:0] tau_reg;
    logic          seen_reg;
    logic [TB-1:0] last_time_reg;
    logic [PB-1:0] last_page_reg;
    logic [SB-1:0] last_stride_reg;
    logic [CB-1:0] conf_reg;
    logic          pending_reg;
    logic [PB-1:0] req_base_reg;
    logic [SB-1:0] req_stride_reg;
    logic [DB-1:0] req_depth_reg;
    logic [AB-1:0] issued_reg;

    // Division working registers.
    logic [NB-1:0] num_reg;
    logic [RB-1:0] rem_reg;
    logic [BB-1:0] drem_reg;
    logic [DB-1:0] quot_reg;

    // Output register.
    logic          out_issue_reg;
    logic [PB-1:0] out_base_reg;
    logic [SB-1:0] out_stride_reg;
    logic [DB-1:0] out_depth_reg;
    logic [AB-1:0] out_tau_reg;
    logic [CB-1:0] out_conf_reg;
    logic [AB-1:0] out_fired_reg;

    logic                 time_ahead;
    logic [TB-1:0]        time_diff;
    logic [WIDE_BITS-1:0] time_diff_wide;
    logic [AB-1:0]        elapsed;
    logic [NB-1:0]        num_calc;
    logic [SB-1:0]        cur_stride;
    logic [CB-1:0]        conf_calc;

    logic [EB-1:0]        rem_ext;
    logic [MB-1:0]        recip_prod;
    logic [GB-1:0]        q_digit;
    logic [RB-1:0]        rem_next;
    logic [NB-1:0]        num_next;

    logic [AB:0]          tau_plus;
    logic [XB-1:0]        dsub;
    logic                 dge;

    logic [DB-1:0]        depth_low;
    logic [DB-1:0]        depth_clamped;
    logic                 fire;
    logic                 issue_now;
    logic [PB-1:0]        req_base_next;
    logic [SB-1:0]        req_stride_next;
    logic [DB-1:0]        req_depth_next;
    logic [AB-1:0]        issued_next;

    assign time_ahead     = time_reg > last_time_reg;
    assign time_diff      = time_reg - last_time_reg;
    assign time_diff_wide = WIDE_BITS'(time_diff);
    assign elapsed        = (time_diff_wide > WIDE_BITS'(65'h0_FFFF_FFFF)) ?
                            '1 : time_diff_wide[AB-1:0];
    assign num_calc       = NB'(tau_reg) * NB'(spp_pkg::TAU_OLD_WEIGHT)
                          + NB'(elapsed) * NB'(spp_pkg::TAU_NEW_WEIGHT);

    assign status.is_start   = kind_reg;
    assign status.tau_update = seen_reg && time_ahead;

    always_comb
    begin
        cur_stride = SB'(WIDE_BITS'(page_reg) - WIDE_BITS'(last_page_reg));
        if (cur_stride == last_stride_reg)
        begin
            conf_calc = (conf_reg < conf_limit_reg) ? conf_reg + 1'b1 : conf_limit_reg;
        end
        else
        begin
            conf_calc = (conf_reg > CB'(2)) ? conf_reg - CB'(2) : '0;
        end
    end

    // One quotient byte per step: the partial remainder stays below 100, so
    // the scaled reciprocal gives the exact digit for every value it sees.
    assign rem_ext    = {rem_reg, num_reg[NB-1 -: GB]};
    assign recip_prod = MB'(rem_ext) * MB'(spp_pkg::DIV_RECIP);
    assign q_digit    = recip_prod[spp_pkg::DIV_RECIP_SHIFT +: GB];
    assign rem_next   = RB'(rem_ext - EB'(q_digit) * EB'(spp_pkg::TAU_DIVISOR));
    assign num_next   = {num_reg[NB-GB-1:0], q_digit};

    assign tau_plus = {1'b0, tau_reg} + (AB + 1)'(1);
    assign dsub     = XB'(tau_plus) << cmd.depth_shift;
    assign dge      = XB'(drem_reg) >= dsub;

    always_comb
    begin
        depth_low       = (quot_reg == '0) ? DB'(1) : quot_reg;
        depth_clamped   = (depth_low > depth_limit_reg) ? depth_limit_reg : depth_low;
        fire            = !kind_reg && (conf_reg >= conf_threshold_reg)
                          && (last_stride_reg != '0);
        issue_now       = fire && !pending_reg;
        req_base_next   = fire ? page_reg : req_base_reg;
        req_stride_next = fire ? last_stride_reg : req_stride_reg;
        req_depth_next  = fire ? depth_clamped : req_depth_reg;
        issued_next     = issue_now ? issued_reg + 1'b1 : issued_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg         <= BB'(12000);
            conf_threshold_reg <= CB'(3);
            conf_limit_reg     <= CB'(8);
            depth_limit_reg    <= DB'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                spp_pkg::REG_DEPTH_BUDGET:   budget_reg         <= cfg_wdata[BB-1:0];
                spp_pkg::REG_CONF_THRESHOLD: conf_threshold_reg <= cfg_wdata[CB-1:0];
                spp_pkg::REG_CONF_LIMIT:     conf_limit_reg     <= cfg_wdata[CB-1:0];
                spp_pkg::REG_DEPTH_LIMIT:    depth_limit_reg    <= cfg_wdata[DB-1:0];
                default:                     budget_reg         <= budget_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg         <= AB'(10000);
            seen_reg        <= 1'b0;
            last_time_reg   <= '0;
            last_page_reg   <= '0;
            last_stride_reg <= SB'(1);
            conf_reg        <= '0;
            pending_reg     <= 1'b0;
            req_base_reg    <= '0;
            req_stride_reg  <= '0;
            req_depth_reg   <= '0;
            issued_reg      <= '0;
        end
        else
        begin
            if (cmd.calc)
            begin
                seen_reg      <= 1'b1;
                last_time_reg <= time_reg;
                last_page_reg <= page_reg;
                conf_reg      <= conf_calc;
                if (cur_stride != last_stride_reg)
                begin
                    last_stride_reg <= cur_stride;
                end
            end
            if (cmd.div_step && cmd.div_last)
            begin
                tau_reg <= num_next[AB-1:0];
            end
            if (cmd.finish)
            begin
                req_base_reg   <= req_base_next;
                req_stride_reg <= req_stride_next;
                req_depth_reg  <= req_depth_next;
                issued_reg     <= issued_next;
                if (kind_reg)
                begin
                    pending_reg <= 1'b0;
                end
                else if (issue_now)
                begin
                    pending_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            page_reg <= in_page_id;
            time_reg <= in_time_us;
            drem_reg <= budget_reg;
            quot_reg <= '0;
        end
        if (cmd.calc)
        begin
            num_reg <= num_calc;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
        if (cmd.depth_step)
        begin
            quot_reg[cmd.depth_shift] <= dge;
            if (dge)
            begin
                drem_reg <= drem_reg - dsub[BB-1:0];
            end
        end
        if (cmd.finish)
        begin
            out_issue_reg  <= issue_now;
            out_base_reg   <= req_base_next;
            out_stride_reg <= req_stride_next;
            out_depth_reg  <= req_depth_next;
            out_tau_reg    <= tau_reg;
            out_conf_reg   <= conf_reg;
            out_fired_reg  <= issued_next;
        end
    end

    assign issue       = out_issue_reg;
    assign base_page   = out_base_reg;
    assign stride      = out_stride_reg;
    assign depth       = out_depth_reg;
    assign tau_us      = out_tau_reg;
    assign confidence  = out_conf_reg;
    assign fired_count = out_fired_reg;

endmodule

@@ hw/rtl/stride_prefetch_predictor.sv @@
// ----------------------------------------------------------------------------
// stride_prefetch_predictor
// Stride prefetch predictor with a confidence counter and a smoothed
// inter-arrival estimate that sets the prefetch depth.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  s_*      in         one event per transfer: read hit or prefetch start
//  m_*      out        one result per event: request, tau, confidence, count
//  cfg_*    in         register writes, taken while the block is idle only by
//                      user rule; the block itself leaves this unenforced
//  A prefetch-start event goes from the transfer through calc to finish; a
//  read also takes a four-step restoring division for the depth, and one
//  that updates the average first divides by 100 at one byte per cycle.
//  The average is not updated on the first read or when the elapsed time
//  is not positive. A stalled output holds the next result in its final state
//  and blocks the input. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module stride_prefetch_predictor
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [spp_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [spp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // page_id, time_us, zero pad
    input  logic [spp_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // base_page, stride, depth, tau_us, confidence, fired_count, zero pad
    output logic [spp_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // issue
    output logic                                 m_tuser
);

    spp_pkg::spp_cmd_t    cmd;
    spp_pkg::spp_status_t status;

    logic [spp_pkg::PAGE_ID_BITS-1:0]       base_page;
    logic signed [spp_pkg::STRIDE_BITS-1:0] stride;
    logic [spp_pkg::DEPTH_BITS-1:0]         depth;
    logic [spp_pkg::TAU_BITS-1:0]           tau_us;
    logic [spp_pkg::CONF_BITS-1:0]          confidence;
    logic [spp_pkg::TAU_BITS-1:0]           fired_count;

    spp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spp_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_kind     (s_tuser),
        .in_page_id  (s_tdata[spp_pkg::PAGE_ID_BITS-1:0]),
        .in_time_us  (s_tdata[spp_pkg::PAGE_ID_BITS +: spp_pkg::TIME_BITS]),
        .cmd         (cmd),
        .status      (status),
        .issue       (m_tuser),
        .base_page   (base_page),
        .stride      (stride),
        .depth       (depth),
        .tau_us      (tau_us),
        .confidence  (confidence),
        .fired_count (fired_count)
    );

    assign m_tdata = spp_pkg::M_TDATA_BITS'({fired_count, confidence, tau_us, depth,
                                             stride, base_page});

endmodule

@@ dv/tb_stride_prefetch_predictor.sv @@
// ----------------------------------------------------------------------------
// tb_stride_prefetch_predictor
// Self-checking testbench for the stride prefetch predictor. A directed table
// covers reset behavior, time that stalls or wraps, saturated gaps, extreme
// page ids, zero strides and the register extremes. Strided page runs with
// random content and some noise follow, over several register settings. Every
// result is compared field by field, in the first rows with literal values and
// else with an in-bench model of the moving average, stride confidence and requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stride_prefetch_predictor;

    localparam int CFG_ADDR_BITS  = spp_pkg::CFG_ADDR_BITS;
    localparam int CFG_DATA_BITS  = spp_pkg::CFG_DATA_BITS;
    localparam int PAGE_ID_BITS   = spp_pkg::PAGE_ID_BITS;
    localparam int TIME_BITS      = spp_pkg::TIME_BITS;
    localparam int STRIDE_BITS    = spp_pkg::STRIDE_BITS;
    localparam int DEPTH_BITS     = spp_pkg::DEPTH_BITS;
    localparam int TAU_BITS       = spp_pkg::TAU_BITS;
    localparam int CONF_BITS      = spp_pkg::CONF_BITS;
    localparam int BUDGET_BITS    = spp_pkg::BUDGET_BITS;
    localparam int S_TDATA_BITS   = spp_pkg::S_TDATA_BITS;
    localparam int M_TDATA_BITS   = spp_pkg::M_TDATA_BITS;
    localparam int TAU_OLD_WEIGHT = spp_pkg::TAU_OLD_WEIGHT;
    localparam int TAU_NEW_WEIGHT = spp_pkg::TAU_NEW_WEIGHT;
    localparam int TAU_DIVISOR    = spp_pkg::TAU_DIVISOR;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam int OFS_STRIDE = PAGE_ID_BITS;
    localparam int OFS_DEPTH  = OFS_STRIDE + STRIDE_BITS;
    localparam int OFS_TAU    = OFS_DEPTH + DEPTH_BITS;
    localparam int OFS_CONF   = OFS_TAU + TAU_BITS;
    localparam int OFS_FIRED  = OFS_CONF + CONF_BITS;

    localparam int DIR_ROWS         = 27;
    localparam int PHASES           = 6;
    localparam int PHASE_ITEMS      = 196;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 60;

    localparam logic [PAGE_ID_BITS-1:0] PAGE_MAX = '1;
    localparam logic [TIME_BITS-1:0]    TIME_MAX = '1;

    typedef struct packed {
        logic                          issue;
        logic [PAGE_ID_BITS-1:0]       base_page;
        logic signed [STRIDE_BITS-1:0] stride;
        logic [DEPTH_BITS-1:0]         depth;
        logic [TAU_BITS-1:0]           tau_us;
        logic [CONF_BITS-1:0]          confidence;
        logic [31:0]                   fired_count;
    } pf_result_t;

    localparam pf_result_t NO_WANT = '0;

    typedef enum logic { ROW_EVENT, ROW_CONFIG } row_act_t;

    typedef struct {
        row_act_t                act;
        logic                    kind;
        logic [PAGE_ID_BITS-1:0] page;
        logic [TIME_BITS-1:0]    stamp;
        bit                      lit;
        pf_result_t              want;
        logic [BUDGET_BITS-1:0]  budget;
        logic [CONF_BITS-1:0]    thr;
        logic [CONF_BITS-1:0]    clim;
        logic [DEPTH_BITS-1:0]   dlim;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     m_tuser;

    pf_result_t pending_results [$];
    dir_row_t   dir_table [DIR_ROWS];
    int         err_count = 0;
    bit         gaps_on   = 1'b1;
    bit         stall_on  = 1'b1;
    bit         hold_req  = 1'b0;

    logic [BUDGET_BITS-1:0]  cfg_budget      = 16'd12000;
    logic [CONF_BITS-1:0]    cfg_threshold   = 4'd3;
    logic [CONF_BITS-1:0]    cfg_conf_limit  = 4'd8;
    logic [DEPTH_BITS-1:0]   cfg_depth_limit = 4'd8;

    logic [TAU_BITS-1:0]     est_tau     = 32'd10000;
    bit                      have_prev   = 1'b0;
    logic [TIME_BITS-1:0]    prev_time   = '0;
    logic [PAGE_ID_BITS-1:0] prev_page   = '0;
    logic [STRIDE_BITS-1:0]  prev_stride = 32'd1;
    logic [CONF_BITS-1:0]    conf_cnt    = '0;
    bit                      req_pending = 1'b0;
    logic [PAGE_ID_BITS-1:0] req_base    = '0;
    logic [STRIDE_BITS-1:0]  req_stride  = '0;
    logic [DEPTH_BITS-1:0]   req_depth   = '0;
    logic [31:0]             fire_total  = '0;

    stride_prefetch_predictor dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pf_result_t predict_event(input logic kind,
                                                 input logic [PAGE_ID_BITS-1:0] page,
                                                 input logic [TIME_BITS-1:0] now);
        logic [63:0]            elapsed;
        logic [63:0]            quot;
        logic [STRIDE_BITS-1:0] cur;
        pf_result_t             r;
        r.issue = 1'b0;
        if (kind == KIND_START)
        begin
            req_pending = 1'b0;
        end
        else
        begin
            if (have_prev && now > prev_time)
            begin
                elapsed = 64'(now - prev_time);
                if (elapsed > 64'hFFFF_FFFF)
                    elapsed = 64'hFFFF_FFFF;
                est_tau = TAU_BITS'((64'(TAU_OLD_WEIGHT) * est_tau
                                     + 64'(TAU_NEW_WEIGHT) * elapsed) / 64'(TAU_DIVISOR));
            end
            have_prev = 1'b1;
            prev_time = now;
            cur = page[STRIDE_BITS-1:0] - prev_page[STRIDE_BITS-1:0];
            if (cur == prev_stride)
            begin
                conf_cnt = (conf_cnt < cfg_conf_limit) ? conf_cnt + 4'd1 : cfg_conf_limit;
            end
            else
            begin
                conf_cnt = (conf_cnt > 4'd2) ? conf_cnt - 4'd2 : 4'd0;
                prev_stride = cur;
            end
            prev_page = page;
            if (conf_cnt >= cfg_threshold && prev_stride != '0)
            begin
                quot = 64'(cfg_budget) / (64'(est_tau) + 64'd1);
                if (quot < 64'd1)
                    quot = 64'd1;
                if (quot > 64'(cfg_depth_limit))
                    quot = 64'(cfg_depth_limit);
                req_base   = page;
                req_stride = prev_stride;
                req_depth  = quot[DEPTH_BITS-1:0];
                if (!req_pending)
                begin
                    req_pending = 1'b1;
                    r.issue     = 1'b1;
                    fire_total  = fire_total + 32'd1;
                end
            end
        end
        r.base_page   = req_base;
        r.stride      = req_stride;
        r.depth       = req_depth;
        r.tau_us      = est_tau;
        r.confidence  = conf_cnt;
        r.fired_count = fire_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    task automatic send_event(input logic kind, input logic [PAGE_ID_BITS-1:0] page,
                              input logic [TIME_BITS-1:0] stamp, input bit lit,
                              input pf_result_t want);
        logic [S_TDATA_BITS-1:0] word;
        pf_result_t              predicted;
        word = '0;
        word[0 +: PAGE_ID_BITS] = page;
        word[PAGE_ID_BITS +: TIME_BITS] = stamp;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_event(kind, page, stamp);
        pending_results.push_back(lit ? want : predicted);
    endtask

    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [BUDGET_BITS-1:0] budget,
                                input logic [CONF_BITS-1:0] thr,
                                input logic [CONF_BITS-1:0] clim,
                                input logic [DEPTH_BITS-1:0] dlim);
        write_reg(spp_pkg::REG_DEPTH_BUDGET, budget);
        write_reg(spp_pkg::REG_CONF_THRESHOLD, CFG_DATA_BITS'(thr));
        write_reg(spp_pkg::REG_CONF_LIMIT, CFG_DATA_BITS'(clim));
        write_reg(spp_pkg::REG_DEPTH_LIMIT, CFG_DATA_BITS'(dlim));
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_budget      = budget;
        cfg_threshold   = thr;
        cfg_conf_limit  = clim;
        cfg_depth_limit = dlim;
    endtask

    always @(posedge clk)
    begin : result_check
        pf_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transfer", m_tdata[63:0], '0);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("issue", 64'(m_tuser), 64'(want.issue));
                check_field("base_page", 64'(m_tdata[0 +: PAGE_ID_BITS]),
                            64'(want.base_page));
                check_field("stride", 64'(m_tdata[OFS_STRIDE +: STRIDE_BITS]),
                            64'(unsigned'(want.stride)));
                check_field("depth", 64'(m_tdata[OFS_DEPTH +: DEPTH_BITS]),
                            64'(want.depth));
                check_field("tau_us", 64'(m_tdata[OFS_TAU +: TAU_BITS]), 64'(want.tau_us));
                check_field("confidence", 64'(m_tdata[OFS_CONF +: CONF_BITS]),
                            64'(want.confidence));
                check_field("fired_count", 64'(m_tdata[OFS_FIRED +: 32]),
                            64'(want.fired_count));
            end
        end
    end

    initial
    begin : receiver
        int n;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int                      i;
        int                      ph;
        int                      phase_sent;
        int                      run_len;
        int                      k;
        int                      mode;
        bit                      paused;
        dir_row_t                row;
        logic [PAGE_ID_BITS-1:0] pg;
        logic [TIME_BITS-1:0]    t_now;
        logic [TIME_BITS-1:0]    t_rand;
        logic [TIME_BITS-1:0]    gap;
        logic [STRIDE_BITS-1:0]  st;
        logic [BUDGET_BITS-1:0]  b;
        logic [CONF_BITS-1:0]    th;
        logic [CONF_BITS-1:0]    cl;
        logic [DEPTH_BITS-1:0]   dl;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_READ;

        dir_table = '{
            '{ROW_EVENT, KIND_READ, 52'd1, 48'd100, 1'b1,
              {1'b0, 52'd0, 32'd0, 4'd0, 32'd10000, 4'd1, 32'd0}, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd2, 48'd100, 1'b1,
              {1'b0, 52'd0, 32'd0, 4'd0, 32'd10000, 4'd2, 32'd0}, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd3, 48'd50, 1'b1,
              {1'b1, 52'd3, 32'd1, 4'd1, 32'd10000, 4'd3, 32'd1}, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd4, 48'd50, 1'b1,
              {1'b0, 52'd4, 32'd1, 4'd1, 32'd10000, 4'd4, 32'd1}, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_START, PAGE_MAX, TIME_MAX, 1'b1,
              {1'b0, 52'd4, 32'd1, 4'd1, 32'd10000, 4'd4, 32'd1}, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_START, 52'd0, 48'd0, 1'b1,
              {1'b0, 52'd4, 32'd1, 4'd1, 32'd10000, 4'd4, 32'd1}, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd5, TIME_MAX, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd6, 48'd0, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, PAGE_MAX, 48'd1, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd0, 48'd2, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd0, 48'd3, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd0, 48'd4, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_CONFIG, KIND_READ, 52'd0, 48'd0, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd15, 4'd15},
            '{ROW_EVENT, KIND_START, 52'd0, 48'd0, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd10, 48'd10, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd20, 48'd20, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd30, 48'd30, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd40, 48'd40, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_CONFIG, KIND_READ, 52'd0, 48'd0, 1'b0, NO_WANT, 16'hFFFF, 4'd2, 4'd2, 4'd0},
            '{ROW_EVENT, KIND_START, 52'd0, 48'd0, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd50, 48'd50, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd60, 48'd60, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_CONFIG, KIND_READ, 52'd0, 48'd0, 1'b0, NO_WANT, 16'hFFFF, 4'd0, 4'd15, 4'd15},
            '{ROW_EVENT, KIND_READ, 52'd57, 48'd61, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd54, 48'd62, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_START, 52'd0, 48'd0, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0},
            '{ROW_EVENT, KIND_READ, 52'd51, 48'd63, 1'b0, NO_WANT, 16'd0, 4'd0, 4'd0, 4'd0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_table[i];
            if (row.act == ROW_CONFIG)
            begin
                drain_results();
                program_regs(row.budget, row.thr, row.clim, row.dlim);
            end
            else
            begin
                send_event(row.kind, row.page, row.stamp, row.lit, row.want);
                sender_gap();
            end
        end

        t_now = 48'd1000;
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            if (ph == 0)
            begin
                b = 16'd12000; th = 4'd3; cl = 4'd8; dl = 4'd8;
            end
            else if (ph == PHASES - 1)
            begin
                b = 16'hFFFF; th = 4'd1; cl = 4'd15; dl = 4'd15;
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       b = 16'd1;
                    1:       b = 16'hFFFF;
                    default: b = 16'($urandom_range(2000, 65535));
                endcase
                th = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 3));
                cl = 4'($urandom_range(1, 15));
                dl = 4'($urandom_range(0, 15));
            end
            program_regs(b, th, cl, dl);
            if (ph == 2)
                hold_req = 1'b1;
            phase_sent = 0;
            paused = 1'b0;
            while (phase_sent < PHASE_ITEMS)
            begin
                if (ph == 3 && !paused && phase_sent >= 100)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) < 8)
                begin
                    run_len = $urandom_range(3, 24);
                    pg = PAGE_ID_BITS'({$urandom, $urandom});
                    case ($urandom_range(0, 3))
                        0, 1:    st = STRIDE_BITS'($urandom_range(0, 16)) - 32'd8;
                        2:       st = $urandom;
                        default: st = $urandom_range(0, 1) ? 32'd0
                                                           : STRIDE_BITS'($urandom_range(1, 4096));
                    endcase
                    mode = $urandom_range(0, 15);
                    for (k = 0; k < run_len && phase_sent < PHASE_ITEMS; k++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            send_event(KIND_START, PAGE_ID_BITS'({$urandom, $urandom}),
                                       TIME_BITS'({$urandom, $urandom}), 1'b0, NO_WANT);
                            sender_gap();
                            phase_sent++;
                        end
                        if (mode == 0)
                            gap = TIME_BITS'({$urandom_range(1, 255), $urandom});
                        else if (mode <= 5)
                            gap = TIME_BITS'($urandom_range(1, 64));
                        else
                            gap = TIME_BITS'($urandom_range(200, 20000));
                        if ($urandom_range(0, 19) == 0)
                            gap = '0;
                        t_now = t_now + gap;
                        if ($urandom_range(0, 19) == 0)
                            pg = pg + PAGE_ID_BITS'($urandom_range(1, 1000));
                        send_event(KIND_READ, pg, t_now, 1'b0, NO_WANT);
                        sender_gap();
                        phase_sent++;
                        pg = pg + {{(PAGE_ID_BITS - STRIDE_BITS){st[STRIDE_BITS-1]}}, st};
                    end
                end
                else
                begin
                    t_rand = TIME_BITS'({$urandom, $urandom});
                    if ($urandom_range(0, 1) == 1)
                        t_now = t_rand;
                    send_event($urandom_range(0, 1) ? KIND_START : KIND_READ,
                               PAGE_ID_BITS'({$urandom, $urandom}), t_rand, 1'b0, NO_WANT);
                    sender_gap();
                    phase_sent++;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/spp_pkg.sv
hw/rtl/spp_ctrl.sv
hw/rtl/spp_datapath.sv
hw/rtl/stride_prefetch_predictor.sv
dv/tb_stride_prefetch_predictor.sv
